[hdl/scc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the strongly connected component labeler
// no dependencies
package scc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 1024;

    localparam int NIDX_W = $clog2(MAX_NODES);
    localparam int NCNT_W = NIDX_W + 1;
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EIDX_W + 1;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] src_node;
        logic [5:0] dst_node;
    } t_in_item;

    typedef struct packed {
        logic [5:0] node_id;
        logic [5:0] component_id;
        logic [6:0] component_count;
        logic       last_node;
        logic       edges_dropped;
    } t_out_item;

endpackage

[hdl/scc_tarjan_labeler.sv]
`timescale 1ns / 1ps
// strongly connected component labeler, tarjan search over an edge store; depends on scc_pkg
// an edge load or clear transaction is handled in the idle state
// a run scans the edge store once per visited node, with entry, stack pop and return
// steps per node, then reads out the results one node at a time
// one transaction at a time; the edge memory read port sets the scan rate
// reset (synchronous, active low) empties the edge store, clears overflow, node count 64
module scc_tarjan_labeler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  scc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output scc_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata
);

    localparam int NI = scc_pkg::NIDX_W;
    localparam int NC = scc_pkg::NCNT_W;
    localparam int EI = scc_pkg::EIDX_W;
    localparam int EC = scc_pkg::ECNT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ROOT    = 4'd1;
    localparam logic [3:0] S_ENTER   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_EDGE    = 4'd4;
    localparam logic [3:0] S_LOWW    = 4'd5;
    localparam logic [3:0] S_FINISH  = 4'd6;
    localparam logic [3:0] S_POP_RD  = 4'd7;
    localparam logic [3:0] S_POP_WR  = 4'd8;
    localparam logic [3:0] S_RET     = 4'd9;
    localparam logic [3:0] S_RET_LD  = 4'd10;
    localparam logic [3:0] S_RET_LD2 = 4'd11;
    localparam logic [3:0] S_EMIT_RD = 4'd12;
    localparam logic [3:0] S_EMIT_LD = 4'd13;

    // memories: edge store, per-node discovery/low/label, tarjan stack, call frames
    logic [11:0]      m_edge  [scc_pkg::MAX_EDGES];
    logic [NC-1:0]    m_disc  [scc_pkg::MAX_NODES];
    logic [NC-1:0]    m_low   [scc_pkg::MAX_NODES];
    logic [NI-1:0]    m_label [scc_pkg::MAX_NODES];
    logic [NI-1:0]    m_stack [scc_pkg::MAX_NODES];
    logic [NI+EC-1:0] m_frame [scc_pkg::MAX_NODES];

    logic [11:0]      r_edge_q;
    logic [NC-1:0]    r_disc_q;
    logic [NC-1:0]    r_low_q;
    logic [NI-1:0]    r_label_q;
    logic [NI-1:0]    r_stack_q;
    logic [NI+EC-1:0] r_frame_q;

    // control state
    logic [3:0]            r_state;
    logic [EC-1:0]         r_etot;
    logic                  r_ovf;
    logic [NC-1:0]         r_n;
    logic [NC-1:0]         r_root;     // root scan, then result index
    logic [NC-1:0]         r_clk_cnt;
    logic [NC-1:0]         r_comp;
    logic [NC-1:0]         r_depth;    // frames parked in the frame memory
    logic [NC-1:0]         r_sp;
    logic [scc_pkg::MAX_NODES-1:0] r_visited;
    logic [scc_pkg::MAX_NODES-1:0] r_onstack;

    // current frame
    logic [NI-1:0] r_v;
    logic [NI-1:0] r_w;
    logic [EC-1:0] r_e;
    logic [NC-1:0] r_disc;
    logic [NC-1:0] r_low;

    logic r_out_valid;
    scc_pkg::t_out_item r_out;

    // decoded edge from the memory output register
    logic [NI-1:0] w_es;
    logic [NI-1:0] w_ew;
    assign w_es = r_edge_q[11:6];
    assign w_ew = r_edge_q[5:0];

    // frame memory output fields
    logic [NI-1:0] w_fp;
    logic [EC-1:0] w_fe;
    assign w_fp = r_frame_q[NI+EC-1:EC];
    assign w_fe = r_frame_q[EC-1:0];

    logic w_in_acc;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // read/write controls for the low-link memory (shared by several states)
    logic          w_low_we;
    logic [NI-1:0] w_low_wa;
    logic [NC-1:0] w_low_wd;
    logic [NI-1:0] w_low_ra;

    always_comb begin
        w_low_we = 1'b0;
        w_low_wa = r_v;
        w_low_wd = r_low;
        w_low_ra = w_ew;
        case (r_state)
            S_ENTER: begin
                w_low_we = 1'b1;
                w_low_wa = r_w;
                w_low_wd = r_clk_cnt;
            end
            S_EDGE: begin
                // write back current low before descending into a new node
                w_low_we = (w_es == r_v) && ({1'b0, w_ew} < r_n) && !r_visited[w_ew];
            end
            S_FINISH: w_low_we = 1'b1;
            S_RET_LD: w_low_ra = w_fp;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_low_we) begin
            m_low[w_low_wa] <= w_low_wd;
        end
        r_low_q <= m_low[w_low_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ENTER) begin
            m_disc[r_w] <= r_clk_cnt;
        end
        r_disc_q <= m_disc[w_fp];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.func == scc_pkg::FUNC_ADD &&
            r_etot < EC'(scc_pkg::MAX_EDGES)) begin
            m_edge[r_etot[EI-1:0]] <= {i_in_data.src_node, i_in_data.dst_node};
        end
        r_edge_q <= m_edge[r_e[EI-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ENTER) begin
            m_stack[r_sp[NI-1:0]] <= r_w;
        end
        r_stack_q <= m_stack[NI'(r_sp - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_POP_WR) begin
            m_label[r_stack_q] <= r_comp[NI-1:0];
        end
        r_label_q <= m_label[r_root[NI-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_low_we && r_state == S_EDGE) begin
            m_frame[r_depth[NI-1:0]] <= {r_v, EC'(r_e + 1'b1)};
        end
        r_frame_q <= m_frame[NI'(r_depth - 1'b1)];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_etot      <= '0;
            r_ovf       <= 1'b0;
            r_n         <= NC'(scc_pkg::MAX_NODES);
            r_root      <= '0;
            r_clk_cnt   <= '0;
            r_comp      <= '0;
            r_depth     <= '0;
            r_sp        <= '0;
            r_visited   <= '0;
            r_onstack   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // zero acts as one node, anything above capacity as full capacity
                if (i_cfg_wdata == '0) begin
                    r_n <= NC'(1);
                end else if (i_cfg_wdata > 7'(scc_pkg::MAX_NODES)) begin
                    r_n <= NC'(scc_pkg::MAX_NODES);
                end else begin
                    r_n <= NC'(i_cfg_wdata);
                end
            end

            // the emit state reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != S_EMIT_LD) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in_data.func)
                            scc_pkg::FUNC_ADD: begin
                                if (r_etot < EC'(scc_pkg::MAX_EDGES)) begin
                                    r_etot <= r_etot + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            scc_pkg::FUNC_CLEAR: begin
                                r_etot <= '0;
                                r_ovf  <= 1'b0;
                            end
                            scc_pkg::FUNC_RUN: begin
                                r_root    <= '0;
                                r_clk_cnt <= '0;
                                r_comp    <= '0;
                                r_depth   <= '0;
                                r_sp      <= '0;
                                r_visited <= '0;
                                r_onstack <= '0;
                                r_state   <= S_ROOT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROOT: begin
                    if (r_root == r_n) begin
                        r_root  <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (r_visited[r_root[NI-1:0]]) begin
                        r_root <= r_root + 1'b1;
                    end else begin
                        r_w     <= r_root[NI-1:0];
                        r_state <= S_ENTER;
                    end
                end
                S_ENTER: begin
                    r_visited[r_w] <= 1'b1;
                    r_onstack[r_w] <= 1'b1;
                    r_v       <= r_w;
                    r_disc    <= r_clk_cnt;
                    r_low     <= r_clk_cnt;
                    r_e       <= '0;
                    r_clk_cnt <= r_clk_cnt + 1'b1;
                    r_sp      <= r_sp + 1'b1;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    // edge memory read issued at r_e
                    r_state <= (r_e == r_etot) ? S_FINISH : S_EDGE;
                end
                S_EDGE: begin
                    r_e     <= r_e + 1'b1;
                    r_state <= S_SCAN;
                    if ((w_es == r_v) && ({1'b0, w_ew} < r_n)) begin
                        if (!r_visited[w_ew]) begin
                            r_depth <= r_depth + 1'b1;
                            r_w     <= w_ew;
                            r_state <= S_ENTER;
                        end else if (r_onstack[w_ew] && (w_ew != r_v)) begin
                            r_state <= S_LOWW;
                        end
                    end
                end
                S_LOWW: begin
                    if (r_low_q < r_low) begin
                        r_low <= r_low_q;
                    end
                    r_state <= S_SCAN;
                end
                S_FINISH: begin
                    r_state <= (r_disc == r_low) ? S_POP_RD : S_RET;
                end
                S_POP_RD: r_state <= S_POP_WR;
                S_POP_WR: begin
                    r_onstack[r_stack_q] <= 1'b0;
                    r_sp <= r_sp - 1'b1;
                    if (r_stack_q == r_v) begin
                        r_comp  <= r_comp + 1'b1;
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_POP_RD;
                    end
                end
                S_RET: begin
                    if (r_depth == '0) begin
                        r_root  <= r_root + 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_RET_LD;
                    end
                end
                S_RET_LD: begin
                    // parent frame arrives; its low and discovery reads go out now
                    r_depth <= r_depth - 1'b1;
                    r_w     <= w_fp;
                    r_e     <= w_fe;
                    r_state <= S_RET_LD2;
                end
                S_RET_LD2: begin
                    if (r_onstack[r_v] && (r_low < r_low_q)) begin
                        r_low <= r_low;
                    end else begin
                        r_low <= r_low_q;
                    end
                    r_v     <= r_w;
                    r_disc  <= r_disc_q;
                    r_state <= S_SCAN;
                end
                S_EMIT_RD: r_state <= S_EMIT_LD;
                S_EMIT_LD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out.node_id         <= r_root[NI-1:0];
                        r_out.component_id    <= NI'(r_comp[NI-1:0] - 1'b1 - r_label_q);
                        r_out.component_count <= r_comp;
                        r_out.last_node       <= (NC'(r_root + 1'b1) == r_n);
                        r_out.edges_dropped   <= r_ovf;
                        r_root <= r_root + 1'b1;
                        r_state <= (NC'(r_root + 1'b1) == r_n) ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench for scc_tarjan_labeler: random and directed graphs, checked by a
// component-labeling scoreboard built into this file
// depends on scc_pkg and scc_tarjan_labeler
module testbench;

    // the unused function code, which the block must ignore
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 500;

    // scoreboard: keeps its own edge store and node count, runs the search on
    // every accepted run transaction and queues the labels it should see
    class scc_scoreboard;
        logic [5:0] edge_from[scc_pkg::MAX_EDGES];
        logic [5:0] edge_to[scc_pkg::MAX_EDGES];
        int         edge_cnt;
        bit         dropped;
        logic [6:0] nodes_cfg;
        scc_pkg::t_out_item label_q[$];
        int         errors;
        int         runs;
        int         labels_seen;

        function new();
            edge_cnt = 0;
            dropped = 0;
            nodes_cfg = 7'd64;
            errors = 0;
            runs = 0;
            labels_seen = 0;
        endfunction

        function void set_nodes(logic [6:0] v);
            nodes_cfg = v;
        endfunction

        // iterative tarjan, out-edges in load order, roots ascending
        function void label_graph(int n);
            bit        seen[scc_pkg::MAX_NODES];
            bit        on_stk[scc_pkg::MAX_NODES];
            int        disc[scc_pkg::MAX_NODES];
            int        low[scc_pkg::MAX_NODES];
            int        comp[scc_pkg::MAX_NODES];
            int        stk[scc_pkg::MAX_NODES];
            int        frame_v[scc_pkg::MAX_NODES];
            int        frame_e[scc_pkg::MAX_NODES];
            int        sp, fp, tick, ncomp, v, e, w, t, p;
            bit        went_down;
            scc_pkg::t_out_item r;
            for (int i = 0; i < scc_pkg::MAX_NODES; i++) begin
                seen[i] = 0;
                on_stk[i] = 0;
            end
            sp = 0; fp = 0; tick = 0; ncomp = 0;
            for (int root = 0; root < n; root++) begin
                if (seen[root]) continue;
                seen[root] = 1; disc[root] = tick; low[root] = tick; tick++;
                stk[sp++] = root; on_stk[root] = 1;
                frame_v[fp] = root; frame_e[fp] = 0; fp++;
                while (fp > 0) begin
                    v = frame_v[fp-1];
                    e = frame_e[fp-1];
                    went_down = 0;
                    while (e < edge_cnt) begin
                        w = edge_to[e];
                        t = edge_from[e];
                        e++;
                        if (t != v || w >= n) continue;
                        frame_e[fp-1] = e;
                        if (!seen[w]) begin
                            seen[w] = 1; disc[w] = tick; low[w] = tick; tick++;
                            stk[sp++] = w; on_stk[w] = 1;
                            frame_v[fp] = w; frame_e[fp] = 0; fp++;
                            went_down = 1;
                            break;
                        end
                        if (on_stk[w] && low[w] < low[v]) low[v] = low[w];
                    end
                    if (went_down) continue;
                    frame_e[fp-1] = e;
                    if (disc[v] == low[v]) begin
                        while (on_stk[v] && sp > 0) begin
                            sp--;
                            t = stk[sp];
                            comp[t] = ncomp;
                            on_stk[t] = 0;
                        end
                        ncomp++;
                    end
                    fp--;
                    if (fp > 0) begin
                        p = frame_v[fp-1];
                        if (on_stk[v] && low[v] < low[p]) low[p] = low[v];
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                r.node_id = 6'(i);
                r.component_id = 6'(ncomp - 1 - comp[i]);
                r.component_count = 7'(ncomp);
                r.last_node = (i == n - 1);
                r.edges_dropped = dropped;
                label_q.push_back(r);
            end
        endfunction

        function void note_input(scc_pkg::t_in_item it);
            int n;
            case (it.func)
                scc_pkg::FUNC_ADD: begin
                    if (edge_cnt < scc_pkg::MAX_EDGES) begin
                        edge_from[edge_cnt] = it.src_node;
                        edge_to[edge_cnt] = it.dst_node;
                        edge_cnt++;
                    end else begin
                        dropped = 1;
                    end
                end
                scc_pkg::FUNC_CLEAR: begin
                    edge_cnt = 0;
                    dropped = 0;
                end
                scc_pkg::FUNC_RUN: begin
                    n = nodes_cfg;
                    if (n < 1) n = 1;
                    if (n > scc_pkg::MAX_NODES) n = scc_pkg::MAX_NODES;
                    runs++;
                    label_graph(n);
                end
                default: ;
            endcase
        endfunction

        function void check_label(scc_pkg::t_out_item got);
            scc_pkg::t_out_item want;
            labels_seen++;
            if (label_q.size() == 0) begin
                $error("unexpected result node_id=%0d", got.node_id);
                errors++;
                return;
            end
            want = label_q.pop_front();
            if (got.node_id !== want.node_id) begin
                $error("node_id expected %0d actual %0d", want.node_id, got.node_id);
                errors++;
            end
            if (got.component_id !== want.component_id) begin
                $error("component_id expected %0d actual %0d",
                       want.component_id, got.component_id);
                errors++;
            end
            if (got.component_count !== want.component_count) begin
                $error("component_count expected %0d actual %0d",
                       want.component_count, got.component_count);
                errors++;
            end
            if (got.last_node !== want.last_node) begin
                $error("last_node expected %0d actual %0d", want.last_node, got.last_node);
                errors++;
            end
            if (got.edges_dropped !== want.edges_dropped) begin
                $error("edges_dropped expected %0d actual %0d",
                       want.edges_dropped, got.edges_dropped);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_in_valid = 0;
    scc_pkg::t_in_item  i_in_data = '0;
    logic       i_out_ready = 0;
    logic       i_cfg_we = 0;
    logic [6:0] i_cfg_wdata = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    scc_pkg::t_out_item o_out_data;

    scc_scoreboard sb = new();

    // idle mode: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
    int idle_mode = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;
    int cycles = 0;
    int items_sent = 0;

    always #10 i_clk = ~i_clk;

    scc_tarjan_labeler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // watchdog so a hung block cannot stall the run forever
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // monitors: both sample the pre-edge handshake
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_label(o_out_data);
    end

    // receiver side: random stalls, plus a long hold-off on request that starts
    // once a result is waiting, so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 0;
        end else if (hold_reqs != hold_done && o_out_valid) begin
            hold_done <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 0;
        end else begin
            case (idle_mode)
                0: i_out_ready <= ($urandom_range(99) >= 57);
                1: i_out_ready <= ($urandom_range(99) >= 16);
                default: i_out_ready <= 1;
            endcase
        end
    end

    // one transaction, with an optional random gap in front of it
    task automatic send_item(logic [1:0] f, logic [5:0] s, logic [5:0] d);
        scc_pkg::t_in_item it;
        int pct;
        it.func = f;
        it.src_node = s;
        it.dst_node = d;
        pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 57 : 0;
        if ($urandom_range(99) < pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // stop offering, then wait until every label has arrived and the block settles
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.label_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_nodes(logic [6:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_nodes(v);
    endtask

    // random graph over n live nodes; mostly in-range edges so cycles form
    task automatic random_graph(int n, int nedges);
        logic [5:0] s, d;
        for (int k = 0; k < nedges; k++) begin
            if ($urandom_range(99) < 88) begin
                s = 6'($urandom_range(n - 1));
                d = 6'($urandom_range(n - 1));
            end else begin
                s = 6'($urandom);
                d = 6'($urandom);
            end
            if ($urandom_range(99) < 3) send_item(FUNC_NONE, 6'($urandom), 6'($urandom));
            send_item(scc_pkg::FUNC_ADD, s, d);
        end
        send_item(scc_pkg::FUNC_RUN, 6'($urandom), 6'($urandom));
    endtask

    initial begin
        int n;
        int graphs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty graph at reset size, then a small known graph
        idle_mode = 0;
        send_item(scc_pkg::FUNC_RUN, 6'd0, 6'd0);
        write_nodes(7'd5);
        send_item(scc_pkg::FUNC_ADD, 6'd0, 6'd1);
        send_item(scc_pkg::FUNC_ADD, 6'd1, 6'd2);
        send_item(scc_pkg::FUNC_ADD, 6'd2, 6'd0);
        send_item(scc_pkg::FUNC_ADD, 6'd2, 6'd3);
        send_item(scc_pkg::FUNC_ADD, 6'd3, 6'd3);
        send_item(scc_pkg::FUNC_ADD, 6'd4, 6'd63);
        send_item(scc_pkg::FUNC_ADD, 6'd63, 6'd4);
        send_item(FUNC_NONE, 6'd63, 6'd63);
        send_item(scc_pkg::FUNC_RUN, 6'd63, 6'd0);
        // zero acts as one node, oversize acts as the full range
        write_nodes(7'd0);
        send_item(scc_pkg::FUNC_RUN, 6'd0, 6'd0);
        write_nodes(7'd127);
        send_item(scc_pkg::FUNC_ADD, 6'd63, 6'd0);
        send_item(scc_pkg::FUNC_ADD, 6'd0, 6'd63);
        send_item(scc_pkg::FUNC_RUN, 6'd0, 6'd0);
        write_nodes(7'd1);
        send_item(scc_pkg::FUNC_RUN, 6'd0, 6'd0);
        send_item(scc_pkg::FUNC_CLEAR, 6'd0, 6'd0);
        write_nodes(7'd64);
        send_item(scc_pkg::FUNC_RUN, 6'd0, 6'd0);

        // random graphs across the three idling regimes
        graphs = 0;
        while (graphs < 42) begin
            idle_mode = (graphs < 14) ? 0 : (graphs < 28) ? 1 : 2;
            if (graphs % 2 == 0) begin
                case ($urandom_range(9))
                    0: n = 64;
                    1: n = 1;
                    default: n = $urandom_range(16, 2);
                endcase
                write_nodes(7'(n));
            end
            // long receiver stall while the sender keeps pushing the next graph
            if (graphs == 5 || graphs == 33) hold_reqs++;
            if ($urandom_range(99) < 70) begin
                send_item(scc_pkg::FUNC_CLEAR, 6'($urandom), 6'($urandom));
            end
            random_graph((n > 1) ? n : 2, $urandom_range((n == 64) ? 40 : 14));
            graphs++;
        end

        drain();
        $display("covered %0d transactions, %0d searches, %0d labels checked",
                 items_sent, sb.runs, sb.labels_seen);
        if (sb.errors == 0 && sb.label_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
